### hdl/three_channel_echo_ranger_top_defines.svh
// Assertion macros shared by the ranger's RTL files.
`ifndef THREE_CHANNEL_ECHO_RANGER_TOP_DEFINES_SVH
`define THREE_CHANNEL_ECHO_RANGER_TOP_DEFINES_SVH

// Check a same-cycle implication, disabled while reset is asserted.
`define TER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, disabled while reset is asserted.
`define TER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ter_pkg.sv
// Shared types and constants of the three-channel echo ranger.
package ter_pkg;

  // Default sizing
  localparam int unsigned SensorCountDef = 3;
  localparam int unsigned TimerBitsDef   = 16;

  // Fixed field sizes
  localparam int unsigned EchoChannels = 3;
  localparam int unsigned RangeW       = 16;
  localparam int unsigned IntervalW    = 8;
  localparam int unsigned SensorIdW    = 2;

  // Reset values
  localparam logic [IntervalW-1:0] IntervalReset = 8'd20;
  localparam logic [RangeW-1:0]    RangeReset    = 16'd400;

  // Time-of-flight scaling: cm = ticks * TickUs / UsPerCm
  localparam int unsigned TickUs    = 64;
  localparam int unsigned UsPerCm   = 58;
  localparam int unsigned TickShift = $clog2(TickUs);

  // Tick count from which the distance no longer fits in RangeW bits
  localparam longint unsigned SatTicks =
      ((64'd1 << RangeW) * UsPerCm + TickUs - 1) / TickUs;

  // Reciprocal multiply for the divide by UsPerCm, exact below 2**NumW
  localparam int unsigned NumW      = RangeW + TickShift;
  localparam int unsigned DivShift  = NumW + $clog2(UsPerCm);
  localparam int unsigned RecipW    = NumW + 1;
  localparam longint unsigned DivRecipL =
      ((64'd1 << DivShift) + UsPerCm - 1) / UsPerCm;
  localparam logic [RecipW-1:0] DivRecip = RecipW'(DivRecipL);
  localparam int unsigned ProdW     = NumW + RecipW;

  // One sampled input transaction
  typedef struct packed {
    logic                    timer_tick;
    logic                    ms_tick;
    logic [EchoChannels-1:0] echo;
  } ter_item_t;

  // Trigger scheduler result
  typedef struct packed {
    logic                 fire;
    logic [SensorIdW-1:0] sensor;
  } ter_scan_t;

endpackage

### hdl/ter_if.sv
// Valid/ready channel interfaces for the ranger's input and result transactions.
interface ter_in_if;
  logic valid;
  logic ready;
  logic timer_tick;
  logic ms_tick;
  logic echo_left;
  logic echo_center;
  logic echo_right;

  modport source (output valid, timer_tick, ms_tick, echo_left, echo_center, echo_right,
                  input ready);
  modport sink   (input valid, timer_tick, ms_tick, echo_left, echo_center, echo_right,
                  output ready);
endinterface

interface ter_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_left;
  logic [15:0] range_center;
  logic [15:0] range_right;
  logic        fire;
  logic [1:0]  fire_sensor;
  logic [2:0]  range_updated;

  modport source (output valid, range_left, range_center, range_right, fire, fire_sensor,
                  range_updated, input ready);
  modport sink   (input valid, range_left, range_center, range_right, fire, fire_sensor,
                  range_updated, output ready);
endinterface

### hdl/three_channel_echo_ranger_top.sv
// Top level of the three-channel ultrasonic echo ranger.
//
// item_i carries one sample per transaction: a 64 us timer tick, a
// millisecond tick and the three echo levels. result_o returns one
// transaction per sample: the three stored ranges in centimeters after
// this sample, a trigger strobe with its sensor, and a mask of ranges
// written by this sample. cfg_we_i/cfg_wdata_i load the scan interval.
// A sample lands in an input register; the edge, range and trigger
// logic between that register and the result register is
// combinational, and while the result register is full the sample
// waits in the input register. Throughput is one transaction per cycle
// while the receiver is ready; the range conversion multiplier sits in that logic.
// Reset clears the tick counter, echo history and scan counter, loads
// every range with 400 and the interval with 20, and empties both stages.
// When the receiver stalls, the result register holds, the input register
// keeps (or, if empty, takes) one more sample, and item_i.ready drops.
`include "three_channel_echo_ranger_top_defines.svh"

module three_channel_echo_ranger_top import ter_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = SensorCountDef,
  parameter int unsigned TIMER_BITS   = TimerBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ter_in_if.sink               item_i,
  ter_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [IntervalW-1:0] cfg_wdata_i
);

  ter_item_t                           s1_q;
  logic                                s1_valid_q;
  logic                                out_valid_q;
  logic                                load;
  logic                                fire_q;
  logic [SensorIdW-1:0]                sensor_q;
  logic [EchoChannels-1:0]             updated_q;
  logic [EchoChannels-1:0]             updated;
  logic [EchoChannels-1:0][RangeW-1:0] ranges;
  ter_scan_t                           scan;

  // Move the staged sample into the result register when it is free
  assign load         = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || load;

  // Capture an accepted input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_q.timer_tick <= item_i.timer_tick;
      s1_q.ms_tick    <= item_i.ms_tick;
      s1_q.echo       <= {item_i.echo_right, item_i.echo_center, item_i.echo_left};
    end
  end

  ter_echo #(
    .TimerBits (TIMER_BITS)
  ) u_echo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (load),
    .item_i    (s1_q),
    .ranges_o  (ranges),
    .updated_o (updated)
  );

  ter_scan #(
    .SensorCount (SENSOR_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (load),
    .ms_tick_i   (s1_q.ms_tick),
    .scan_o      (scan)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fire_q    <= scan.fire;
      sensor_q  <= scan.sensor;
      updated_q <= updated;
    end
  end

  // Ranges only change on a load, so the range registers serve as result payload
  assign result_o.valid         = out_valid_q;
  assign result_o.range_left    = ranges[0];
  assign result_o.range_center  = ranges[1];
  assign result_o.range_right   = ranges[2];
  assign result_o.fire          = fire_q;
  assign result_o.fire_sensor   = sensor_q;
  assign result_o.range_updated = updated_q;

  // Checks
  `TER_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !s1_valid_q, item_i.ready,
                  "input stage empty but not ready")
  `TER_ASSERT_NEXT(a_load_fills_result, clk_i, rst_ni, load, out_valid_q,
                   "result register not valid after a load")
  `TER_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, s1_valid_q && !load, s1_valid_q,
                   "staged transaction lost while stalled")
  `TER_ASSERT_NOW(a_fire_needs_ms, clk_i, rst_ni, !s1_q.ms_tick && s1_valid_q, !scan.fire,
                  "trigger without a millisecond tick")

endmodule

### hdl/ter_echo.sv
// Echo edge detection, shared tick counter and per-sensor range registers.
module ter_echo import ter_pkg::*; #(
  parameter int unsigned TimerBits = TimerBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  ter_item_t                            item_i,
  output logic [EchoChannels-1:0][RangeW-1:0]  ranges_o,
  output logic [EchoChannels-1:0]              updated_o
);

  logic [TimerBits-1:0]                timer_q, timer_d;
  logic [EchoChannels-1:0]             prev_q;
  logic [EchoChannels-1:0][RangeW-1:0] range_q, range_d;
  logic [EchoChannels-1:0]             rise, fall;
  logic [31:0]                         timer_ext;
  logic                                sat;
  logic [NumW-1:0]                     numer;
  logic [ProdW-1:0]                    prod;
  logic [RangeW-1:0]                   cm;
  logic                                cleared;

  // Find edges against the previous levels
  assign rise = item_i.echo & ~prev_q;
  assign fall = ~item_i.echo & prev_q;

  // Convert the current tick count to centimeters, saturating
  assign timer_ext = 32'(timer_q);
  assign sat       = (64'(timer_ext) >= SatTicks);
  assign numer     = {timer_ext[RangeW-1:0], {TickShift{1'b0}}};
  assign prod      = ProdW'(numer) * ProdW'(DivRecip);
  assign cm        = sat ? {RangeW{1'b1}} : prod[DivShift +: RangeW];

  // Walk the channels in order; a rising edge zeroes the count seen later
  always_comb begin
    range_d = range_q;
    cleared = 1'b0;
    for (int i = 0; i < EchoChannels; i++) begin
      if (fall[i]) begin
        range_d[i] = cleared ? '0 : cm;
      end
      if (rise[i]) begin
        cleared = 1'b1;
      end
    end
  end

  // Clear on any rising edge, then count the timer tick
  always_comb begin
    timer_d = (|rise) ? '0 : timer_q;
    if (item_i.timer_tick) begin
      timer_d = timer_d + TimerBits'(1);
    end
  end

  // Advance state once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      prev_q  <= '0;
      range_q <= {EchoChannels{RangeReset}};
    end else if (step_i) begin
      timer_q <= timer_d;
      prev_q  <= item_i.echo;
      range_q <= range_d;
    end
  end

  assign ranges_o  = range_q;
  assign updated_o = fall;

endmodule

### hdl/ter_scan.sv
// Scan interval register, millisecond counter and round-robin trigger selection.
module ter_scan import ter_pkg::*; #(
  parameter int unsigned SensorCount = SensorCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IntervalW-1:0] cfg_wdata_i,
  input  logic                 step_i,
  input  logic                 ms_tick_i,
  output ter_scan_t            scan_o
);

  localparam int unsigned NsW = (SensorCount > 1) ? $clog2(SensorCount) : 1;
  localparam logic [NsW-1:0] LastSensor = NsW'(SensorCount - 1);

  logic [IntervalW-1:0] interval_q;
  logic [7:0]           cnt_q, cnt_inc;
  logic [NsW-1:0]       next_q;
  logic                 fire;

  // Saturating count and trigger decision
  assign cnt_inc = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
  assign fire    = ms_tick_i && (cnt_inc >= interval_q);

  // Hold the scan interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  // Advance the counter and rotate the sensor on a trigger
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      next_q <= '0;
    end else if (step_i && ms_tick_i) begin
      cnt_q <= fire ? 8'd0 : cnt_inc;
      if (fire) begin
        next_q <= (next_q == LastSensor) ? '0 : next_q + NsW'(1);
      end
    end
  end

  // The fired sensor and the next one agree before the rotation
  assign scan_o.fire   = fire;
  assign scan_o.sensor = SensorIdW'(next_q);

endmodule
